[sv/odo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, constants and helper functions for the differential drive
// odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] lin_vel;
		logic signed [15:0] ang_vel;
		logic        [15:0] dt_us;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic signed [31:0] left_angle;
		logic signed [31:0] right_angle;
		logic signed [23:0] left_rate;
		logic signed [23:0] right_rate;
		logic signed [15:0] lin_vel_echo;
		logic signed [15:0] ang_vel_echo;
	} out_t;

	typedef enum logic [3:0] {
		OP_TURN,
		OP_RRATE,
		OP_LRATE,
		OP_RANG1,
		OP_RANG2,
		OP_LANG1,
		OP_LANG2,
		OP_DIST1,
		OP_DIST2,
		OP_DX,
		OP_DY,
		OP_DH1,
		OP_DH2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_DONE
	} fsm_t;

	typedef struct packed {
		op_t  op;
		logic mul_en;
		logic wb_en;
		logic in_ready;
		logic out_valid;
	} ctrl_t;

	localparam logic [7:0] REG_HALF_SEP   = 8'd0;
	localparam logic [7:0] REG_INV_RADIUS = 8'd1;

	localparam logic [15:0] HALF_SEP_RESET   = 16'd5472;
	localparam logic [15:0] INV_RADIUS_RESET = 16'd7758;

	localparam logic signed [22:0] K_US   = 23'sd1099512;
	localparam logic signed [22:0] K_HEAD = 23'sd2799883;

	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569306;
	localparam logic [63:0] C7 = 64'd5026996;

	localparam logic signed [63:0] RATE_MAX = 64'sd8388607;
	localparam logic signed [63:0] RATE_MIN = -64'sd8388608;

	function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
		input int unsigned s);
		logic signed [63:0] half;
		half = 64'sd1 <<< (s - 1);
		round_shift = (x + half) >>> s;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
		if (x > RATE_MAX) begin
			sat24 = 24'sh7FFFFF;
		end else if (x < RATE_MIN) begin
			sat24 = -24'sh800000;
		end else begin
			sat24 = x[23:0];
		end
	endfunction

	function automatic logic signed [15:0] sine_entry(input int unsigned k,
		input int unsigned bits);
		logic [63:0]  z;
		logic [63:0]  z2;
		logic [63:0]  r;
		logic [63:0]  s;
		int unsigned  quad;
		quad = k >> (bits - 2);
		z = 64'(k & ((32'd1 << (bits - 2)) - 32'd1)) << (32 - bits);
		if (quad[0]) begin
			z = (64'd1 << 30) - z;
		end
		z2 = (z * z) >> 30;
		r = C7;
		r = C5 - ((z2 * r) >> 30);
		r = C3 - ((z2 * r) >> 30);
		r = C1 - ((z2 * r) >> 30);
		s = (z * r) >> 30;
		s = (s + 64'd32768) >> 16;
		if (s > 64'd16384) begin
			s = 64'd16384;
		end
		sine_entry = quad[1] ? -16'(s) : 16'(s);
	endfunction

endpackage
`default_nettype wire

[sv/odo_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine and cosine table
// Constant full-wave sine table in Q14, indexed by the top bits of the
// heading; both outputs are registered.
// ----------------------------------------------------------------------------
module odo_sine_rom
	import odo_pkg::*;
#(
	parameter int TABLE_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic        [15:0] heading,
	output logic signed      [15:0] sin_q,
	output logic signed      [15:0] cos_q
);

	localparam int TabSize = 1 << TABLE_BITS;

	logic signed [15:0]       rom [TabSize];
	logic [TABLE_BITS-1:0]    idx;
	logic [TABLE_BITS-1:0]    cidx;

	for (genvar k = 0; k < TabSize; k++) begin : g_rom
		assign rom[k] = sine_entry(k, TABLE_BITS);
	end

	assign idx  = heading[15 -: TABLE_BITS];
	assign cidx = idx + TABLE_BITS'(TabSize / 4);

	always_ff @(posedge clk) begin
		sin_q <= rom[idx];
		cos_q <= rom[cidx];
	end

endmodule
`default_nettype wire

[sv/odo_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 41 by 23 bit multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module odo_mul
	import odo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [40:0] a,
	input  wire logic signed [22:0] b,
	output logic signed      [63:0] p_q
);

	logic signed [63:0] prod;

	assign prod = 64'(a) * 64'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod;
		end
	end

endmodule
`default_nettype wire

[sv/odo_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry sequencer
// Steps the shared multiplier through the operations of one tick, alternating
// a multiply state and a write-back state, then holds the result.
// ----------------------------------------------------------------------------
module odo_ctrl
	import odo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic tick_req,
	input  wire logic out_ready,
	output ctrl_t     ctrl
);

	fsm_t state_q;
	fsm_t state_d;
	op_t  op_q;
	op_t  op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_TURN;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		op_d           = op_q;
		ctrl.op        = op_q;
		ctrl.mul_en    = 1'b0;
		ctrl.wb_en     = 1'b0;
		ctrl.in_ready  = 1'b0;
		ctrl.out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid && tick_req) begin
					state_d = ST_MUL;
					op_d    = OP_TURN;
				end
			end
			ST_MUL: begin
				ctrl.mul_en = 1'b1;
				state_d     = ST_WB;
			end
			ST_WB: begin
				ctrl.wb_en = 1'b1;
				if (op_q == OP_DH2) begin
					state_d = ST_DONE;
				end else begin
					op_d    = op_t'(op_q + 4'd1);
					state_d = ST_MUL;
				end
			end
			ST_DONE: begin
				ctrl.out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[sv/diff_drive_odometry_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose and wheel angle integrator built around one shared
// multiplier.
// ----------------------------------------------------------------------------
// A velocity command (cmd 0) only stores the velocities. A tick (cmd 1,
// nonzero dt_us) runs thirteen multiplications on one shared multiplier,
// each as a multiply state followed by a write-back state; in_ready is low
// from the tick's transfer until its result has been transferred. A tick
// with zero dt_us is accepted and gives no result. Configuration writes are
// taken in any cycle.
module diff_drive_odometry_top
	import odo_pkg::*;
#(
	parameter int SINCOS_TABLE_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	ctrl_t              ctrl;
	logic               tick_req;
	logic               in_xfer;

	logic [15:0]        hs_q;
	logic [15:0]        ir_q;
	logic signed [15:0] v_q;
	logic signed [15:0] w_q;
	logic [15:0]        dt_q;

	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic [15:0]        head_q;
	logic signed [31:0] lang_q;
	logic signed [31:0] rang_q;

	logic signed [33:0] rsum_q;
	logic signed [33:0] lsum_q;
	logic signed [23:0] rr_q;
	logic signed [23:0] lr_q;
	logic signed [40:0] t_q;
	logic signed [28:0] dist_q;

	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;

	logic signed [40:0] mul_a;
	logic signed [22:0] mul_b;
	logic signed [63:0] p_q;

	logic signed [33:0] base;
	logic signed [33:0] turn;
	logic signed [63:0] r24;
	logic signed [63:0] r26;
	logic signed [63:0] r28;
	logic signed [63:0] r32;
	logic signed [63:0] r40;

	assign tick_req  = in_data.cmd && (in_data.dt_us != 16'd0);
	assign in_ready  = ctrl.in_ready;
	assign in_xfer   = in_valid && ctrl.in_ready;
	assign out_valid = ctrl.out_valid;
	assign cfg_ready = 1'b1;

	odo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.tick_req  (tick_req),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	odo_sine_rom #(
		.TABLE_BITS (SINCOS_TABLE_BITS)
	) u_rom (
		.clk     (clk),
		.heading (head_q),
		.sin_q   (sin_q),
		.cos_q   (cos_q)
	);

	odo_mul u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	always_comb begin
		mul_a = t_q;
		mul_b = K_US;
		case (ctrl.op)
			OP_TURN: begin
				mul_a = {{25{w_q[15]}}, w_q};
				mul_b = {7'b0, hs_q};
			end
			OP_RRATE: begin
				mul_a = {{7{rsum_q[33]}}, rsum_q};
				mul_b = {7'b0, ir_q};
			end
			OP_LRATE: begin
				mul_a = {{7{lsum_q[33]}}, lsum_q};
				mul_b = {7'b0, ir_q};
			end
			OP_RANG1: begin
				mul_a = {{17{rr_q[23]}}, rr_q};
				mul_b = {7'b0, dt_q};
			end
			OP_LANG1: begin
				mul_a = {{17{lr_q[23]}}, lr_q};
				mul_b = {7'b0, dt_q};
			end
			OP_DIST1: begin
				mul_a = {{25{v_q[15]}}, v_q};
				mul_b = {7'b0, dt_q};
			end
			OP_DX: begin
				mul_a = {{12{dist_q[28]}}, dist_q};
				mul_b = {{7{cos_q[15]}}, cos_q};
			end
			OP_DY: begin
				mul_a = {{12{dist_q[28]}}, dist_q};
				mul_b = {{7{sin_q[15]}}, sin_q};
			end
			OP_DH1: begin
				mul_a = {{25{w_q[15]}}, w_q};
				mul_b = {7'b0, dt_q};
			end
			OP_DH2: begin
				mul_a = t_q;
				mul_b = K_HEAD;
			end
			default: begin
				mul_a = t_q;
				mul_b = K_US;
			end
		endcase
	end

	assign base = {{2{v_q[15]}}, v_q, 16'b0};
	assign turn = {{2{p_q[31]}}, p_q[31:0]};
	assign r24  = round_shift(p_q, 24);
	assign r26  = round_shift(p_q, 26);
	assign r28  = round_shift(p_q, 28);
	assign r32  = round_shift(p_q, 32);
	assign r40  = round_shift(p_q, 40);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= HALF_SEP_RESET;
			ir_q <= INV_RADIUS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_HALF_SEP) begin
				hs_q <= cfg_data;
			end else if (cfg_index == REG_INV_RADIUS) begin
				ir_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			w_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			head_q <= '0;
			lang_q <= '0;
			rang_q <= '0;
		end else begin
			if (in_xfer && !in_data.cmd) begin
				v_q <= in_data.lin_vel;
				w_q <= in_data.ang_vel;
			end
			if (ctrl.wb_en) begin
				case (ctrl.op)
					OP_RANG2: rang_q <= rang_q + r32[31:0];
					OP_LANG2: lang_q <= lang_q + r32[31:0];
					OP_DX:    x_q    <= x_q + r26[31:0];
					OP_DY:    y_q    <= y_q + r26[31:0];
					OP_DH2:   head_q <= head_q + r40[15:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && in_data.cmd) begin
			dt_q <= in_data.dt_us;
		end
		if (ctrl.wb_en) begin
			case (ctrl.op)
				OP_TURN: begin
					rsum_q <= base + turn;
					lsum_q <= base - turn;
				end
				OP_RRATE: rr_q   <= sat24(r28);
				OP_LRATE: lr_q   <= sat24(r28);
				OP_RANG1: t_q    <= p_q[40:0];
				OP_LANG1: t_q    <= p_q[40:0];
				OP_DIST1: t_q    <= p_q[40:0];
				OP_DIST2: dist_q <= r24[28:0];
				OP_DH1:   t_q    <= p_q[40:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		out_data.pos_x        = x_q;
		out_data.pos_y        = y_q;
		out_data.heading      = head_q;
		out_data.left_angle   = lang_q;
		out_data.right_angle  = rang_q;
		out_data.left_rate    = lr_q;
		out_data.right_rate   = rr_q;
		out_data.lin_vel_echo = v_q;
		out_data.ang_vel_echo = w_q;
	end

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives velocity commands and time ticks into the odometry block, predicts
// every pose result with an independent fixed-point model, and compares the
// results field by field under random source gaps, sink stalls and several
// register settings.
// ----------------------------------------------------------------------------
module testbench;
	import odo_pkg::*;

	localparam int          CLK_PERIOD      = 10;
	localparam int          TAB_BITS        = 10;
	localparam int          TAB_SIZE        = 1 << TAB_BITS;
	localparam int          NUM_PHASES      = 7;
	localparam int          ITEMS_PER_PHASE = 160;
	localparam int          DRAIN_CYCLES    = 40;
	localparam logic        CMD_VELOCITY    = 1'b0;
	localparam logic        CMD_TICK        = 1'b1;
	localparam longint      US_SCALE        = 64'sd1099512;
	localparam longint      HEAD_SCALE      = 64'sd2799883;
	localparam longint      RATE_HIGH       = 64'sd8388607;
	localparam longint      RATE_LOW        = -64'sd8388608;
	localparam longint unsigned POLY_C1     = 64'd1686629713;
	localparam longint unsigned POLY_C3     = 64'd693598668;
	localparam longint unsigned POLY_C5     = 64'd85569306;
	localparam longint unsigned POLY_C7     = 64'd5026996;

	class pose_tracker;
		logic signed [15:0] sine_q14 [TAB_SIZE];
		logic        [15:0] half_sep;
		logic        [15:0] inv_radius;
		logic        [31:0] pose_x;
		logic        [31:0] pose_y;
		logic        [15:0] heading;
		logic        [31:0] left_angle;
		logic        [31:0] right_angle;
		logic signed [15:0] lin_vel;
		logic signed [15:0] ang_vel;
		out_t               expected_poses [$];
		int                 errors;

		function new();
			longint unsigned z;
			longint unsigned zz;
			longint unsigned acc;
			int unsigned     quad;
			for (int k = 0; k < TAB_SIZE; k++) begin
				quad = k >> (TAB_BITS - 2);
				z = longint'(k & (TAB_SIZE / 4 - 1)) << (32 - TAB_BITS);
				if (quad[0]) begin
					z = (64'd1 << 30) - z;
				end
				zz = (z * z) >> 30;
				acc = POLY_C5 - ((zz * POLY_C7) >> 30);
				acc = POLY_C3 - ((zz * acc) >> 30);
				acc = POLY_C1 - ((zz * acc) >> 30);
				acc = (((z * acc) >> 30) + 64'd32768) >> 16;
				if (acc > 64'd16384) begin
					acc = 64'd16384;
				end
				sine_q14[k] = quad[1] ? -16'(acc) : 16'(acc);
			end
			half_sep = HALF_SEP_RESET;
			inv_radius = INV_RADIUS_RESET;
			pose_x = '0;
			pose_y = '0;
			heading = '0;
			left_angle = '0;
			right_angle = '0;
			lin_vel = '0;
			ang_vel = '0;
			errors = 0;
		endfunction

		function longint round_down(longint x, int s);
			return (x + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint clamp_rate(longint x);
			if (x > RATE_HIGH) begin
				return RATE_HIGH;
			end
			if (x < RATE_LOW) begin
				return RATE_LOW;
			end
			return x;
		endfunction

		function void write_register(logic [7:0] idx, logic [15:0] data);
			if (idx == REG_HALF_SEP) begin
				half_sep = data;
			end else if (idx == REG_INV_RADIUS) begin
				inv_radius = data;
			end
		endfunction

		function void take_item(in_t item);
			longint      v;
			longint      w;
			longint      dt;
			longint      turn;
			longint      lr;
			longint      rr;
			longint      travel;
			int unsigned idx;
			int unsigned cidx;
			out_t        res;
			if (item.cmd == CMD_VELOCITY) begin
				lin_vel = item.lin_vel;
				ang_vel = item.ang_vel;
				return;
			end
			dt = longint'(item.dt_us);
			if (dt == 0) begin
				return;
			end
			v = longint'(lin_vel);
			w = longint'(ang_vel);
			turn = w * longint'(half_sep);
			rr = clamp_rate(round_down((v * 65536 + turn) * longint'(inv_radius), 28));
			lr = clamp_rate(round_down((v * 65536 - turn) * longint'(inv_radius), 28));
			left_angle = left_angle + 32'(round_down(lr * dt * US_SCALE, 32));
			right_angle = right_angle + 32'(round_down(rr * dt * US_SCALE, 32));
			idx = heading >> (16 - TAB_BITS);
			cidx = (idx + TAB_SIZE / 4) % TAB_SIZE;
			travel = round_down(v * dt * US_SCALE, 24);
			pose_x = pose_x + 32'(round_down(travel * longint'(sine_q14[cidx]), 26));
			pose_y = pose_y + 32'(round_down(travel * longint'(sine_q14[idx]), 26));
			heading = heading + 16'(round_down(w * dt * HEAD_SCALE, 40));
			res.pos_x = pose_x;
			res.pos_y = pose_y;
			res.heading = heading;
			res.left_angle = left_angle;
			res.right_angle = right_angle;
			res.left_rate = 24'(lr);
			res.right_rate = 24'(rr);
			res.lin_vel_echo = lin_vel;
			res.ang_vel_echo = ang_vel;
			expected_poses.push_back(res);
		endfunction

		function void check_field(string name, longint exp_val, longint act_val);
			if (exp_val != act_val) begin
				$error("%s: expected %0d, got %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void compare_pose(out_t got);
			out_t want;
			if (expected_poses.size() == 0) begin
				$error("result transfer with no pending tick");
				errors++;
				return;
			end
			want = expected_poses.pop_front();
			check_field("pos_x", want.pos_x, got.pos_x);
			check_field("pos_y", want.pos_y, got.pos_y);
			check_field("heading", want.heading, got.heading);
			check_field("left_angle", want.left_angle, got.left_angle);
			check_field("right_angle", want.right_angle, got.right_angle);
			check_field("left_rate", want.left_rate, got.left_rate);
			check_field("right_rate", want.right_rate, got.right_rate);
			check_field("lin_vel_echo", want.lin_vel_echo, got.lin_vel_echo);
			check_field("ang_vel_echo", want.ang_vel_echo, got.ang_vel_echo);
		endfunction

		function int pending();
			return expected_poses.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_t         in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	pose_tracker tracker;
	bit          idle_on   = 1'b1;
	int          stall_left = 0;

	diff_drive_odometry_top #(
		.SINCOS_TABLE_BITS(TAB_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			tracker.compare_pose(out_data);
		end
	end

	function automatic in_t make_item(logic cmd, int lin, int ang, int dt);
		in_t it;
		it.cmd = cmd;
		it.lin_vel = 16'(lin);
		it.ang_vel = 16'(ang);
		it.dt_us = 16'(dt);
		return it;
	endfunction

	function automatic logic [15:0] random_velocity();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return 16'($urandom);
		end else if (r < 8) begin
			return 16'($urandom_range(0, 1023) - 512);
		end else if (r == 8) begin
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		end
		return 16'h0000;
	endfunction

	function automatic in_t random_item();
		in_t it;
		int  r;
		it.lin_vel = 16'($urandom);
		it.ang_vel = 16'($urandom);
		it.dt_us = 16'($urandom);
		if ($urandom_range(0, 99) < 35) begin
			it.cmd = CMD_VELOCITY;
			it.lin_vel = random_velocity();
			it.ang_vel = random_velocity();
		end else begin
			it.cmd = CMD_TICK;
			r = $urandom_range(0, 99);
			if (r < 5) begin
				it.dt_us = '0;
			end else if (r < 25) begin
				it.dt_us = 16'($urandom_range(1, 2000));
			end else if (r < 30) begin
				it.dt_us = 16'hFFFF;
			end else begin
				it.dt_us = 16'($urandom_range(1, 65535));
			end
		end
		return it;
	endfunction

	task automatic send_item(input in_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		tracker.take_item(item);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_register(idx, data);
	endtask

	task automatic configure(input logic [15:0] hs, input logic [15:0] ir);
		write_reg(REG_HALF_SEP, hs);
		write_reg(REG_INV_RADIUS, ir);
		write_reg(8'($urandom_range(REG_INV_RADIUS + 1, 255)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		in_t directed [$];
		tracker = new();
		directed.push_back(make_item(CMD_TICK, 0, 0, 1));
		directed.push_back(make_item(CMD_TICK, 0, 0, 0));
		directed.push_back(make_item(CMD_VELOCITY, 32767, 32767, 0));
		directed.push_back(make_item(CMD_TICK, 0, 0, 65535));
		directed.push_back(make_item(CMD_TICK, 0, 0, 1));
		directed.push_back(make_item(CMD_TICK, -1, -1, 0));
		directed.push_back(make_item(CMD_VELOCITY, -32768, -32768, 65535));
		directed.push_back(make_item(CMD_TICK, 0, 0, 65535));
		directed.push_back(make_item(CMD_VELOCITY, 32767, -32768, 0));
		directed.push_back(make_item(CMD_TICK, 0, 0, 65535));
		directed.push_back(make_item(CMD_VELOCITY, -32768, 32767, 0));
		directed.push_back(make_item(CMD_TICK, 0, 0, 65535));
		directed.push_back(make_item(CMD_VELOCITY, 4096, 0, 0));
		directed.push_back(make_item(CMD_TICK, 0, 0, 50000));
		directed.push_back(make_item(CMD_VELOCITY, 0, 8192, 0));
		directed.push_back(make_item(CMD_TICK, 0, 0, 65535));
		directed.push_back(make_item(CMD_TICK, 0, 0, 65535));
		directed.push_back(make_item(CMD_TICK, 0, 0, 65535));
		directed.push_back(make_item(CMD_VELOCITY, -1, -1, 0));
		directed.push_back(make_item(CMD_TICK, 0, 0, 1));
		directed.push_back(make_item(CMD_VELOCITY, 0, 0, 65535));
		directed.push_back(make_item(CMD_TICK, -1, -1, 32768));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			idle_on = (phase % 3) != 2;
			if (phase == 0) begin
				foreach (directed[i]) begin
					send_item(directed[i]);
				end
			end else begin
				wait_drained();
				case (phase)
					1: configure(16'd0, 16'd65535);
					2: configure(16'd65535, 16'd1);
					3: configure(16'd65535, 16'd65535);
					4: configure(16'($urandom), 16'd0);
					5: configure(16'($urandom), 16'($urandom));
					default: configure(HALF_SEP_RESET, INV_RADIUS_RESET);
				endcase
			end
			repeat (ITEMS_PER_PHASE) send_item(random_item());
		end
		wait_drained();
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

[diff_drive_odometry_top.f]
sv/odo_pkg.sv
sv/odo_sine_rom.sv
sv/odo_mul.sv
sv/odo_ctrl.sv
sv/diff_drive_odometry_top.sv
verif/testbench.sv
